// File: hw/rtl/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer; depends on nothing.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry.
   localparam int SCREEN_WIDTH  = 80;
   localparam int SCREEN_HEIGHT = 25;
   localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int COPY_COUNT    = CELL_COUNT - SCREEN_WIDTH;
   localparam int ADDR_W        = $clog2(CELL_COUNT);

   // Field widths.
   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = CHAR_W + ATTR_W;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Characters and attributes.
   localparam logic [CHAR_W-1:0] LINE_FEED       = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'd32;
   localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'd15;

   // Register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_COLOR_ATTRIBUTE = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;           // capture the accepted request word
      logic exec;            // execute the captured word (put, read, clear setup)
      logic fill;            // write a blank cell at the sweep counter
      logic fill_reset_attr; // blank with the reset attribute instead of the register
      logic copy;            // scroll copy step at the sweep counter
      logic blank;           // blank the bottom row at the sweep counter
      logic cnt_clear;
      logic cnt_inc;
      logic rsp_load;        // load the output register
      logic rsp_live;        // take the result from this cycle's next-state values
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic need_scroll;
      logic cnt_at_last;
      logic cnt_at_copy_end;
      logic rsp_free;
   } dp_status_type;

   // Linear cell address, one bit wider than the store needs so that
   // out-of-range coordinates can be caught before truncation.
   function automatic logic [ADDR_W:0] cell_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
      cell_addr = (ADDR_W+1)'(row) * (ADDR_W+1)'(SCREEN_WIDTH) + (ADDR_W+1)'(col);
   endfunction

endpackage

// File: hw/rtl/tcw_ctrl.sv
// Sequencing state machine of the text console writer.
// Depends on tcw_pkg for the command and status structures.
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EXEC  = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_BLANK = 7'b0010000,
      ST_FILL  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill            = 1'b1;
            cmd.fill_reset_attr = 1'b1;
            if (status.cnt_at_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch     = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.is_clear) begin
               state_in = ST_FILL;
            end else if (status.need_scroll) begin
               state_in = ST_COPY;
            end else if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_live = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (status.cnt_at_copy_end) begin
               // The counter now sits on the first cell of the bottom row.
               state_in = ST_BLANK;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_BLANK: begin
            cmd.blank = 1'b1;
            if (status.cnt_at_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            if (status.cnt_at_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// File: hw/rtl/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, sweep counter
// and output register. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tcw_pkg::MODE_W-1:0]        req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]         req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]         req_read_column,
   input  logic [tcw_pkg::ATTR_W-1:0]        attr,
   input  tcw_pkg::dp_cmd_type               cmd,
   output tcw_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcw_pkg::ROW_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]         rsp_cursor_column,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic                              rsp_scrolled
);
   import tcw_pkg::*;

   // Captured request word.
   logic [MODE_W-1:0] mode_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;

   // Cursor and per-item results.
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   logic              scrolled_ff, scrolled_in;

   // Sweep counter.
   logic [ADDR_W-1:0] cnt_ff, cnt_in;

   // Cell store.
   logic [CELL_W-1:0] mem [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [CELL_W-1:0] wr_data;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_scrolled_ff;

   logic              is_put;
   logic              is_lf;
   logic              advance_row;
   logic              need_scroll;
   logic              read_in_range;
   logic              req_in_range;
   logic [ADDR_W:0]   req_addr;
   logic [ADDR_W:0]   put_addr;
   logic [ADDR_W:0]   copy_src;
   logic              rsp_free;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode;
         char_ff <= req_char_code;
         rrow_ff <= req_read_row;
         rcol_ff <= req_read_column;
      end
   end

   // Next cursor for the captured word.
   assign is_put      = (mode_ff == MODE_PUT);
   assign is_lf       = (char_ff == LINE_FEED);
   assign advance_row = is_put && (is_lf || (col_ff == COL_W'(SCREEN_WIDTH - 1)));
   assign need_scroll = advance_row && (row_ff == ROW_W'(SCREEN_HEIGHT - 1));

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (mode_ff == MODE_CLEAR) begin
         row_in = '0;
         col_in = '0;
      end else if (is_put) begin
         if (advance_row) begin
            col_in = '0;
            row_in = need_scroll ? ROW_W'(SCREEN_HEIGHT - 1) : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   assign read_in_range = (32'(rrow_ff) < SCREEN_HEIGHT) && (32'(rcol_ff) < SCREEN_WIDTH);
   assign cell_in       = ((mode_ff == MODE_READ) && read_in_range) ? rd_data_ff : '0;
   assign scrolled_in   = need_scroll;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.exec) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cell_ff     <= cell_in;
         scrolled_ff <= scrolled_in;
      end
   end

   // Sweep counter.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Store addressing. Reads are issued from the request ports while idle so
   // the data is ready in the execute cycle; during a scroll the read runs one
   // row ahead of the write, which writes the registered read data one row up.
   assign req_addr     = cell_addr(req_read_row, req_read_column);
   assign req_in_range = (32'(req_read_row) < SCREEN_HEIGHT) &&
                         (32'(req_read_column) < SCREEN_WIDTH);
   assign put_addr     = cell_addr(row_ff, col_ff);
   assign copy_src     = (ADDR_W+1)'(cnt_ff) + (ADDR_W+1)'(SCREEN_WIDTH);

   always_comb begin
      if (cmd.copy) begin
         rd_addr = (cnt_ff != ADDR_W'(COPY_COUNT)) ? copy_src[ADDR_W-1:0] : '0;
      end else begin
         rd_addr = req_in_range ? req_addr[ADDR_W-1:0] : '0;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff;
      wr_data = {attr, BLANK_CHAR};
      if (cmd.fill) begin
         wr_en   = 1'b1;
         wr_data = {(cmd.fill_reset_attr ? RESET_ATTRIBUTE : attr), BLANK_CHAR};
      end else if (cmd.blank) begin
         wr_en = 1'b1;
      end else if (cmd.copy) begin
         wr_en   = (cnt_ff != '0);
         wr_addr = cnt_ff - 1'b1;
         wr_data = rd_data_ff;
      end else if (cmd.exec && is_put && !is_lf) begin
         wr_en   = 1'b1;
         wr_addr = put_addr[ADDR_W-1:0];
         wr_data = {attr, char_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // Output register.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_row_ff      <= cmd.rsp_live ? row_in      : row_ff;
         rsp_col_ff      <= cmd.rsp_live ? col_in      : col_ff;
         rsp_cell_ff     <= cmd.rsp_live ? cell_in     : cell_ff;
         rsp_scrolled_ff <= cmd.rsp_live ? scrolled_in : scrolled_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

   assign status.is_clear        = (mode_ff == MODE_CLEAR);
   assign status.need_scroll     = need_scroll;
   assign status.cnt_at_last     = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
   assign status.cnt_at_copy_end = (cnt_ff == ADDR_W'(COPY_COUNT));
   assign status.rsp_free        = rsp_free;

endmodule

// File: hw/rtl/text_console_writer.sv
// Top level of the text console writer: register port, controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Carries
// ----------+-----------+--------------------+------------------------------------------
// req_*     | in        | req_valid/ready    | mode, char_code, read_row, read_column
// rsp_*     | out       | rsp_valid/ready    | cursor_row, cursor_column, cell_value,
//           |           |                    | scrolled
// APB       | in/out    | psel/penable       | color_attribute at byte address 0
//
// A put, a read or an unused mode is accepted, then executed against the
// single-port-write, registered-read cell store, and the result lands in the
// output register. A clear sweeps the store one cell per cycle. A put that
// scrolls runs the same store sweep: one copy per cycle for all rows but the
// last, then one blank per cycle for the bottom row. After reset, a clearing
// pass fills the store with blank cells before the first request word is
// accepted; register writes are taken during it.
// A stalled output register holds the finished result; the next request word
// is accepted as soon as the controller is back in idle, so one result can
// wait at the output while the next word is executing.

module text_console_writer (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tcw_pkg::MODE_W-1:0]        req_mode,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]         req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]         req_read_column,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcw_pkg::ROW_W-1:0]         rsp_cursor_row,
   output logic [tcw_pkg::COL_W-1:0]         rsp_cursor_column,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_value,
   output logic                              rsp_scrolled,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import tcw_pkg::*;

   logic [ATTR_W-1:0] attr_ff;
   logic [ATTR_W-1:0] attr_in;
   logic              csr_write;
   logic              csr_hit_color;
   dp_cmd_type        cmd;
   dp_status_type     status;

   // The register port never waits. The color attribute is the only register;
   // its new value applies to cells written or blanked from then on, and cells
   // already in the store keep the attribute they were written with.
   assign pready        = 1'b1;
   assign csr_hit_color = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_COLOR_ATTRIBUTE);
   assign csr_write     = psel && penable && pwrite && pready;
   assign attr_in       = (csr_write && csr_hit_color) ? pwdata[ATTR_W-1:0] : attr_ff;
   assign prdata        = csr_hit_color ? CSR_DATA_W'(attr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTRIBUTE;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // The controller sequences each word; the datapath owns every piece of
   // storage that the words act on, including the output register.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .attr              (attr_ff),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_scrolled      (rsp_scrolled)
   );

   // The reported cursor always lies on the screen.
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row) < SCREEN_HEIGHT) &&
                    (32'(rsp_cursor_column) < SCREEN_WIDTH))
      else $error("cursor reported off screen");

   // A scroll leaves the cursor at the start of the bottom row.
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |->
         (rsp_cursor_row == ROW_W'(SCREEN_HEIGHT - 1)) && (rsp_cursor_column == '0))
      else $error("scroll left the cursor off the bottom row start");

   // Only one word is in execution at a time.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a word is executing");

   // A register write takes effect at the next edge.
   a_attr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit_color) |=> (attr_ff == $past(pwdata[ATTR_W-1:0])))
      else $error("color attribute write lost");

endmodule

// File: verif/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: drives request words and register writes,
// predicts every result word from its own screen image and compares it field by field.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   // Mode 3 has no package constant; the block must treat it as a no-op.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Byte address of the attribute register on the register port.
   localparam logic [CSR_ADDR_W-1:0] COLOR_ATTR_ADDR = {CSR_IDX_COLOR_ATTRIBUTE, 2'b00};

   // Cycles with no handshake of any kind before the run is declared hung. The slowest
   // legal quiet stretch is a scroll or clear sweep followed by a stall on the result
   // side, or the clearing pass after reset.
   localparam int HANG_LIMIT = 10000;

   // Cycles allowed after the last result for a stray extra word to show up.
   localparam int SETTLE_CYCLES = 20;

   // Random words per phase; six phases plus the directed part come to about 700 words.
   localparam int PHASE_WORDS = 113;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  rrow;
      logic [COL_W-1:0]  rcol;
   } console_cmd_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] cell_value;
      logic              scrolled;
   } cursor_report_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [MODE_W-1:0] req_mode = '0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [ROW_W-1:0]  req_read_row = '0;
   logic [COL_W-1:0]  req_read_column = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [COL_W-1:0]  rsp_cursor_column;
   logic [CELL_W-1:0] rsp_cell_value;
   logic              rsp_scrolled;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   text_console_writer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_scrolled      (rsp_scrolled),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // The testbench's own copy of the console: screen image, cursor and attribute.
   logic [CELL_W-1:0] screen_image [CELL_COUNT];
   int                cur_row;
   int                cur_col;
   logic [ATTR_W-1:0] attr_now;

   // Words waiting to be driven, the count of words not yet accepted, and the
   // cursor reports that accepted words still owe.
   console_cmd_type   words_to_send [$];
   int                words_unsent;
   cursor_report_type reports_due [$];

   int  mismatches;
   int  quiet_cycles;
   bit  steady;       // When set, neither side idles or stalls.
   int  send_gap;
   int  stall_left;

   console_cmd_type   launch_word;
   cursor_report_type due_report;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one accepted word to the screen image and returns the report that the
   // block has to produce for it. Text wraps at the right edge, a line feed moves to
   // the start of the next row, and running off the bottom row scrolls the screen up.
   function automatic cursor_report_type apply_console_word(console_cmd_type w);
      cursor_report_type r;
      int                i;
      r = '0;
      case (w.mode)
         MODE_PUT: begin
            if (w.ch == LINE_FEED) begin
               cur_col = 0;
               cur_row++;
            end else begin
               i = cur_row * SCREEN_WIDTH + cur_col;
               if (i < CELL_COUNT) screen_image[i] = {attr_now, w.ch};
               cur_col++;
               if (cur_col >= SCREEN_WIDTH) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            if (cur_row >= SCREEN_HEIGHT) begin
               for (i = 0; i < COPY_COUNT; i++) screen_image[i] = screen_image[i + SCREEN_WIDTH];
               for (i = COPY_COUNT; i < CELL_COUNT; i++) screen_image[i] = {attr_now, BLANK_CHAR};
               cur_row = SCREEN_HEIGHT - 1;
               r.scrolled = 1'b1;
            end
         end
         MODE_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) screen_image[i] = {attr_now, BLANK_CHAR};
            cur_row = 0;
            cur_col = 0;
         end
         MODE_READ: begin
            // Coordinates off the screen read as zero.
            if (w.rrow < SCREEN_HEIGHT && w.rcol < SCREEN_WIDTH)
               r.cell_value = screen_image[w.rrow * SCREEN_WIDTH + w.rcol];
         end
         default: ;  // The unused mode leaves everything as it is.
      endcase
      r.row = ROW_W'(cur_row);
      r.col = COL_W'(cur_col);
      return r;
   endfunction

   // Mostly printable text with line feeds and reads, so the cursor walks down the
   // screen and the bottom row scrolls often. Full-range characters, reads off the
   // screen, the unused mode and clears are mixed in at lower rates. Clears are kept
   // rare because each one sends the cursor back to the top row.
   function automatic console_cmd_type random_console_word();
      console_cmd_type w;
      int              pick;
      w.mode = MODE_PUT;
      w.ch   = CHAR_W'($urandom_range(32, 126));
      w.rrow = ROW_W'($urandom_range(0, 31));
      w.rcol = COL_W'($urandom_range(0, 127));
      pick   = $urandom_range(0, 399);
      if (pick < 1) begin
         w.mode = MODE_CLEAR;
      end else if (pick < 9) begin
         w.mode = MODE_UNUSED;
      end else if (pick < 75) begin
         w.mode = MODE_READ;
         if ($urandom_range(0, 9) != 0) begin
            w.rrow = ROW_W'($urandom_range(0, SCREEN_HEIGHT - 1));
            w.rcol = COL_W'($urandom_range(0, SCREEN_WIDTH - 1));
         end
      end else if (pick < 125) begin
         w.ch = LINE_FEED;
      end else if (pick < 190) begin
         w.ch = CHAR_W'($urandom_range(0, 255));
      end
      return w;
   endfunction

   task automatic queue_word(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] c,
                             input logic [ROW_W-1:0] r, input logic [COL_W-1:0] k);
      words_to_send.push_back({m, c, r, k});
      words_unsent++;
   endtask

   // Holds the sender back until every queued word has been accepted and every
   // report has come back. Must be entered right after a rising edge.
   task automatic drain_console();
      while (words_unsent != 0 || reports_due.size() != 0) @(posedge clock);
   endtask

   // Register write followed by a read back, each as a setup and an access cycle.
   // The block is idle whenever this runs, so the attribute can change at once.
   task automatic set_attribute(input logic [ATTR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= COLOR_ATTR_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      attr_now = value;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[ATTR_W-1:0] !== attr_now) begin
         mismatches++;
         $display("%0t: color_attribute read back expected %02h actual %02h",
                  $time, attr_now, prdata[ATTR_W-1:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Request driver. A new word is launched only when the slot is free, that is when
   // nothing is held or the held word is being taken at this edge. Each valid is set
   // exactly once per edge so a word that follows another directly keeps valid high.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            reports_due.push_back(apply_console_word({req_mode, req_char_code,
                                                      req_read_row, req_read_column}));
            words_unsent--;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 16) - 1;
               req_valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
               launch_word = words_to_send.pop_front();
               req_mode        <= launch_word.mode;
               req_char_code   <= launch_word.ch;
               req_read_row    <= launch_word.rrow;
               req_read_column <= launch_word.rcol;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted report is matched against the oldest one owed;
   // rsp_ready is dropped in random bursts unless the run is in its steady part.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result word row %0d col %0d cell %04h scrolled %0d",
                        $time, rsp_cursor_row, rsp_cursor_column, rsp_cell_value,
                        rsp_scrolled);
            end else begin
               due_report = reports_due.pop_front();
               if (rsp_cursor_row !== due_report.row) begin
                  mismatches++;
                  $display("%0t: cursor_row expected %0d actual %0d",
                           $time, due_report.row, rsp_cursor_row);
               end
               if (rsp_cursor_column !== due_report.col) begin
                  mismatches++;
                  $display("%0t: cursor_column expected %0d actual %0d",
                           $time, due_report.col, rsp_cursor_column);
               end
               if (rsp_cell_value !== due_report.cell_value) begin
                  mismatches++;
                  $display("%0t: cell_value expected %04h actual %04h",
                           $time, due_report.cell_value, rsp_cell_value);
               end
               if (rsp_scrolled !== due_report.scrolled) begin
                  mismatches++;
                  $display("%0t: scrolled expected %0d actual %0d",
                           $time, due_report.scrolled, rsp_scrolled);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hang detector: any handshake on either channel or the register port restarts it.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      console_cmd_type w;
      int              p;
      int              n;
      mismatches   = 0;
      quiet_cycles = 0;
      words_unsent = 0;
      steady       = 1'b0;
      send_gap     = 0;
      stall_left   = 0;

      // After reset the block sweeps the store to blanks with the reset attribute.
      attr_now = RESET_ATTRIBUTE;
      cur_row  = 0;
      cur_col  = 0;
      for (n = 0; n < CELL_COUNT; n++) screen_image[n] = {RESET_ATTRIBUTE, BLANK_CHAR};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, still under the reset attribute. Reads of two corners and of
      // coordinates off the screen, the unused mode, character extremes, a line feed,
      // then a clear, a read of the freshly blanked home cell, a blank put and a read.
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd255, 5'd24, 7'd79);
      queue_word(MODE_READ, 8'd0, 5'd25, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd80);
      queue_word(MODE_READ, 8'd0, 5'd31, 7'd127);
      queue_word(MODE_UNUSED, 8'd255, 5'd31, 7'd127);
      queue_word(MODE_PUT, 8'h41, 5'd0, 7'd0);
      queue_word(MODE_PUT, 8'h00, 5'd0, 7'd0);
      queue_word(MODE_PUT, 8'hFF, 5'd31, 7'd127);
      queue_word(MODE_PUT, 8'h7F, 5'd0, 7'd0);
      queue_word(MODE_PUT, 8'h80, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd1);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd2);
      queue_word(MODE_PUT, LINE_FEED, 5'd0, 7'd0);
      queue_word(MODE_PUT, 8'h55, 5'd0, 7'd0);
      queue_word(MODE_PUT, 8'hAA, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd1, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd1, 7'd2);
      queue_word(MODE_CLEAR, 8'd0, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd0);
      queue_word(MODE_PUT, BLANK_CHAR, 5'd0, 7'd0);
      queue_word(MODE_READ, 8'd0, 5'd0, 7'd0);
      drain_console();

      // Random phases, each under its own attribute. The sender pauses at every phase
      // boundary until all reports are back, and the register is changed only then.
      // Cells written earlier must keep the attribute they were written with.
      for (p = 0; p < 6; p++) begin
         case (p)
            0:       set_attribute(8'h00);
            1:       set_attribute(8'hFF);
            default: set_attribute(ATTR_W'($urandom_range(0, 255)));
         endcase
         // The last phase runs with no idling on either side.
         if (p == 5) steady = 1'b1;
         for (n = 0; n < PHASE_WORDS; n++) begin
            w = random_console_word();
            queue_word(w.mode, w.ch, w.rrow, w.rcol);
         end
         drain_console();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
